/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpe assertion failed");

// Next-cycle implication.
`define HPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpe assertion failed");

`endif

/* design/hpe_pkg.sv */
// Types, constants and microprogram of the Hermite polynomial evaluator.
package hpe_pkg;

  localparam int IN_W  = 18;
  localparam int OUT_W = 59;
  localparam int CFG_W = 5;
  localparam int LO_W  = 30;
  localparam int PC_W  = 3;

  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_LOOP = 3'd1;
  localparam logic [PC_W-1:0] PC_EMIT = 3'd7;
  localparam int UCODE_LEN = 8;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_X_LO,
    MUL_X_HI,
    MUL_K_LO,
    MUL_K_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_START,
    JMP_LOOP,
    JMP_EMIT
  } jump_t;

  typedef struct packed {
    mul_sel_t        mul;
    acc_op_t         acc;
    logic            take_in;
    logic            update;
    logic            emit;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic zero_deg;
    logic out_free;
  } status_t;

  localparam ctrl_t UCODE [UCODE_LEN] = '{
    '{MUL_NONE, ACC_HOLD, 1'b1, 1'b0, 1'b0, JMP_START, PC_EMIT},
    '{MUL_X_LO, ACC_HOLD, 1'b0, 1'b0, 1'b0, JMP_NEXT,  PC_IDLE},
    '{MUL_X_HI, ACC_LOAD, 1'b0, 1'b0, 1'b0, JMP_NEXT,  PC_IDLE},
    '{MUL_K_LO, ACC_ADD,  1'b0, 1'b0, 1'b0, JMP_NEXT,  PC_IDLE},
    '{MUL_K_HI, ACC_ADD,  1'b0, 1'b0, 1'b0, JMP_NEXT,  PC_IDLE},
    '{MUL_NONE, ACC_ADD,  1'b0, 1'b0, 1'b0, JMP_NEXT,  PC_IDLE},
    '{MUL_NONE, ACC_HOLD, 1'b0, 1'b1, 1'b0, JMP_LOOP,  PC_EMIT},
    '{MUL_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b1, JMP_EMIT,  PC_IDLE}
  };

endpackage

/* design/hpe_if.sv */
// Stream interfaces for the sample input and the result output.
interface hpe_in_if import hpe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface hpe_out_if import hpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] poly_value;

  modport source (output valid, output poly_value, input ready);
  modport sink   (input valid, input poly_value, output ready);
endinterface

/* design/hpe_sequencer.sv */
// Microcode sequencer: step counter, control store and jump logic.
module hpe_sequencer import hpe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;

  assign ctrl = UCODE[pc_r];

  always_comb begin
    pc_nxt = pc_r;
    unique case (ctrl.jump)
      JMP_NEXT:  pc_nxt = pc_r + 1'b1;
      JMP_START: begin
        if (in_valid) begin
          pc_nxt = status.zero_deg ? ctrl.target : pc_r + 1'b1;
        end
      end
      JMP_LOOP:  pc_nxt = status.last ? ctrl.target : PC_LOOP;
      JMP_EMIT:  pc_nxt = status.out_free ? ctrl.target : pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* design/hpe_datapath.sv */
// Datapath: degree register, shared multiplier, accumulator and output register.
module hpe_datapath import hpe_pkg::*; #(
  parameter int MAX_DEGREE = 20,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_fire,
  input  logic signed [IN_W-1:0]  in_x,
  input  ctrl_t                   ctrl,
  output status_t                 status,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_poly
);

  localparam int KW     = $clog2(MAX_DEGREE + 1);
  localparam int PROD_W = IN_W + LO_W + 1;
  localparam int ACC_W  = OUT_W + IN_W + FRAC_BITS + 1;

  localparam logic [CFG_W-1:0] DEG_MAX = CFG_W'(MAX_DEGREE);
  localparam logic [OUT_W-1:0] H_ONE   =
    {{(OUT_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [OUT_W-1:0] H_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] H_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  logic [CFG_W-1:0]        degree_r;
  logic [CFG_W-1:0]        deg_cl;
  logic [KW-1:0]           n_r;
  logic [KW-1:0]           k_r;
  logic signed [IN_W-1:0]  x_r;
  logic signed [OUT_W-1:0] h_prev_r;
  logic signed [OUT_W-1:0] h_cur_r;
  logic signed [PROD_W-1:0] prod_r;
  mul_sel_t                tag_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_poly_r;

  logic signed [IN_W-1:0]  a_op;
  logic signed [LO_W:0]    b_op;
  logic signed [IN_W-1:0]  k2;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] sh;
  logic [ACC_W-OUT_W:0]    sh_top;
  logic [OUT_W-1:0]        h_sat;
  logic                    out_load;

  assign deg_cl = (degree_r > DEG_MAX) ? DEG_MAX : degree_r;
  assign k2     = {{(IN_W-KW-1){1'b0}}, k_r, 1'b0};

  assign status.zero_deg = (deg_cl == '0);
  assign status.last     = (({1'b0, k_r} + 1'b1) == {1'b0, n_r});
  assign status.out_free = !out_valid_r || out_ready;

  assign out_load  = ctrl.emit && status.out_free;
  assign out_valid = out_valid_r;
  assign out_poly  = out_poly_r;

  always_comb begin
    case (ctrl.mul)
      MUL_X_LO: begin
        a_op = x_r;
        b_op = {1'b0, h_cur_r[LO_W-1:0]};
      end
      MUL_X_HI: begin
        a_op = x_r;
        b_op = {{(2*LO_W+1-OUT_W){h_cur_r[OUT_W-1]}}, h_cur_r[OUT_W-1:LO_W]};
      end
      MUL_K_LO: begin
        a_op = k2;
        b_op = {1'b0, h_prev_r[LO_W-1:0]};
      end
      MUL_K_HI: begin
        a_op = k2;
        b_op = {{(2*LO_W+1-OUT_W){h_prev_r[OUT_W-1]}}, h_prev_r[OUT_W-1:LO_W]};
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (tag_r)
      MUL_X_LO: term = prod_ext;
      MUL_X_HI: term = prod_ext <<< LO_W;
      MUL_K_LO: term = -(prod_ext <<< (FRAC_BITS - 1));
      MUL_K_HI: term = -(prod_ext <<< (LO_W + FRAC_BITS - 1));
      default:  term = '0;
    endcase
  end

  assign sh     = acc_r >>> (FRAC_BITS - 1);
  assign sh_top = sh[ACC_W-1:OUT_W-1];
  assign h_sat  = ((&sh_top) || !(|sh_top)) ? sh[OUT_W-1:0]
                : (sh[ACC_W-1] ? H_MIN : H_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        degree_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a_op * b_op);
    tag_r  <= ctrl.mul;
    case (ctrl.acc)
      ACC_LOAD: acc_r <= term;
      ACC_ADD:  acc_r <= acc_r + term;
      default:  acc_r <= acc_r;
    endcase
    if (in_fire) begin
      x_r      <= in_x;
      h_prev_r <= '0;
      h_cur_r  <= H_ONE;
      k_r      <= '0;
      n_r      <= deg_cl[KW-1:0];
    end else if (ctrl.update) begin
      h_prev_r <= h_cur_r;
      h_cur_r  <= h_sat;
      k_r      <= k_r + 1'b1;
    end
    if (out_load) begin
      out_poly_r <= h_cur_r;
    end
  end

endmodule

/* design/hermite_polynomial_eval.sv */
// Hermite polynomial evaluator top level: H_n(x) by recurrence for each sample.
//
// Each sample x (signed, FRAC_BITS fractional bits) yields H_n(x) for the degree n
// held in the degree register, clamped to MAX_DEGREE. A sample is taken only while
// the sequencer waits at its idle step; it then runs six steps per recurrence step
// and the emit step, which loads the result into the output register once that is
// free. The six steps per recurrence step come from the one shared 18 x 31
// multiplier, used four times per step for the two halves of 2x*H(k) and
// 2k*H(k-1), followed by accumulation and the saturating update.
// A new sample is accepted while the previous result still waits for transfer.
// Write the degree only while no sample is in flight.
`include "assert_macros.svh"

module hermite_polynomial_eval import hpe_pkg::*; #(
  parameter int MAX_DEGREE = 20,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  hpe_in_if.sink           in_chan,
  hpe_out_if.source        out_chan
);

  ctrl_t   ctrl;
  status_t status;
  logic    in_fire;

  assign in_chan.ready = ctrl.take_in;
  assign in_fire       = in_chan.valid && ctrl.take_in;

  hpe_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  hpe_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_x      (in_chan.x_value),
    .ctrl      (ctrl),
    .status    (status),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_poly  (out_chan.poly_value)
  );

  `HPE_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_fire, !in_chan.ready)
  `HPE_ASSERT_NXT(a_emit_sets_valid, clk, rst_n, ctrl.emit && status.out_free, out_chan.valid)
  `HPE_ASSERT_IMP(a_valid_from_emit, clk, rst_n, $rose(out_chan.valid), $past(ctrl.emit))
  `HPE_ASSERT_IMP(a_no_take_in_update, clk, rst_n, ctrl.update, !in_chan.ready && !ctrl.emit)

endmodule

/* test/hermite_polynomial_eval_tb.sv */
// Self-checking testbench for the Hermite polynomial evaluator, checked against a recurrence model.
`timescale 1ns / 1ps

module hermite_polynomial_eval_tb import hpe_pkg::*; ();

  localparam int MAX_DEG    = 20;
  localparam int FRAC       = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 156;

  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (OUT_W - 1));

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  hpe_in_if  in_if ();
  hpe_out_if out_if ();

  hermite_polynomial_eval uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  logic signed [IN_W-1:0]  x_pending[$];
  logic signed [OUT_W-1:0] poly_expected[$];
  logic [CFG_W-1:0]        degree_reg;
  int                      x_queued;
  int                      x_accepted;
  int                      errors;
  int                      idle_cycles;
  int                      send_wait;
  int                      recv_wait;
  bit                      send_burst;
  bit                      recv_burst;
  logic                    x_taken;
  logic                    poly_taken;

  function automatic logic signed [OUT_W-1:0] hermite_fixed(input logic signed [IN_W-1:0] x,
                                                            input logic [CFG_W-1:0] deg);
    logic signed [127:0] x_w;
    logic signed [127:0] h_prev;
    logic signed [127:0] h_cur;
    logic signed [127:0] h_next;
    logic signed [127:0] two_k;
    int                  n;
    int                  k;
    x_w    = x;
    n      = (deg > MAX_DEG) ? MAX_DEG : int'(deg);
    h_prev = '0;
    h_cur  = 128'sd1 <<< FRAC;
    for (k = 0; k < n; k++) begin
      two_k  = 2 * k;
      h_next = ((x_w * h_cur) >>> (FRAC - 1)) - two_k * h_prev;
      if (h_next > SAT_HI) h_next = SAT_HI;
      else if (h_next < SAT_LO) h_next = SAT_LO;
      h_prev = h_cur;
      h_cur  = h_next;
    end
    return h_cur[OUT_W-1:0];
  endfunction

  always #5 clk = ~clk;

  // Monitor: predict on input transfer, check on output transfer.
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    if (!rst_n) begin
      x_taken    <= 1'b0;
      poly_taken <= 1'b0;
      degree_reg = '0;
    end else begin
      x_taken    <= in_if.valid && in_if.ready;
      poly_taken <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        poly_expected.push_back(hermite_fixed(in_if.x_value, degree_reg));
        x_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (poly_expected.size() == 0) begin
          $error("unexpected result: poly_value %0d", out_if.poly_value);
          errors++;
        end else begin
          want = poly_expected.pop_front();
          if (out_if.poly_value !== want) begin
            $error("poly_value mismatch: expected %0d, got %0d", want, out_if.poly_value);
            errors++;
          end
        end
      end
      if (cfg_we) degree_reg = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Driver: present queued samples, hold until transfer, then wait a drawn gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || x_taken) begin
      if (send_wait > 0) begin
        send_wait--;
        in_if.valid <= 1'b0;
      end else if (x_pending.size() > 0) begin
        in_if.x_value <= x_pending.pop_front();
        in_if.valid   <= 1'b1;
        send_wait = send_burst ? 0 : $urandom_range(0, 10);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (poly_taken) recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
      if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_x(input logic signed [IN_W-1:0] x);
    x_pending.push_back(x);
    x_queued++;
  endtask

  task automatic wait_drained();
    while (x_accepted != x_queued || poly_expected.size() != 0) @(negedge clk);
  endtask

  task automatic set_degree(input logic [CFG_W-1:0] d);
    wait_drained();
    cfg_wdata <= d;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic signed [IN_W-1:0] corner_x[6];
    logic [CFG_W-1:0]       corner_deg[4];
    logic [CFG_W-1:0]       deg;
    logic signed [IN_W-1:0] x;
    int                     pick;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.x_value = '0;
    out_if.ready  = 1'b0;
    x_queued      = 0;
    x_accepted    = 0;
    errors        = 0;
    send_wait     = 0;
    recv_wait     = 0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    corner_x      = '{18'sd0, 18'sd65536, -18'sd65536, 18'sd131071, -18'sd131072, 18'sd21845};
    corner_deg    = '{5'd20, 5'd31, 5'd1, 5'd21};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // degree stays at its reset value for the first set
    foreach (corner_x[i]) push_x(corner_x[i]);
    for (int d = 0; d < 3; d++) begin
      set_degree(corner_deg[d]);
      foreach (corner_x[i]) push_x(corner_x[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      deg = (p == 0) ? 5'd0 : (p < 4) ? corner_deg[p] : 5'($urandom_range(0, 31));
      set_degree(deg);
      send_burst = (p % 4 == 1);
      recv_burst = (p % 4 == 2);
      for (int i = 0; i < PHASE_LEN; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) x = IN_W'(int'($urandom_range(0, 131072)) - 65536);
        else if (pick == 8) x = IN_W'($urandom);
        else x = corner_x[$urandom_range(0, 5)];
        push_x(x);
        // hold off the sender once until the results drain
        if (p == 5 && i == PHASE_LEN / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (6 * MAX_DEG + 10) @(negedge clk);
    if (poly_expected.size() != 0) begin
      $error("%0d results never arrived", poly_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
